@@ hw/rtl/mds_pkg.sv @@
// Shared constants, register codes and servo step function for the mecanum drive block.
`default_nettype none

package mds_pkg;

   localparam int STICK_WIDTH_DEF = 8;
   localparam int BUTTON_WIDTH    = 4;
   localparam int SWITCH_WIDTH    = 4;
   localparam int GAIN_WIDTH      = 8;
   localparam int PWM_WIDTH       = 17;
   localparam int SERVO_WIDTH     = 12;
   localparam int NUM_WHEELS      = 4;
   localparam int NUM_SERVOS      = 4;
   localparam int CSR_IDX_WIDTH   = 2;

   localparam logic [PWM_WIDTH-1:0] PWM_MAX = '1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GAIN_SLOW = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GAIN_FAST = 2'd1;

   localparam logic [GAIN_WIDTH-1:0] GAIN_SLOW_RESET = 8'd10;
   localparam logic [GAIN_WIDTH-1:0] GAIN_FAST_RESET = 8'd50;

   // switch that picks the fast gain
   localparam int SW_GAIN_SEL = 3;

   typedef logic [SERVO_WIDTH-1:0] servo_width_type;

   localparam servo_width_type SERVO_RESET [NUM_SERVOS] =
      '{12'd1000, 12'd1500, 12'd1800, 12'd2500};
   localparam servo_width_type SERVO_LOW   [NUM_SERVOS] =
      '{12'd500, 12'd500, 12'd500, 12'd1500};
   localparam servo_width_type SERVO_HIGH  [NUM_SERVOS] =
      '{12'd2500, 12'd1800, 12'd2500, 12'd2500};
   localparam servo_width_type SERVO_STEP  [NUM_SERVOS] =
      '{12'd25, 12'd50, 12'd40, 12'd50};

   // Limit is tested before the step, so a width may pass the limit once.
   function automatic servo_width_type servo_step(
      input servo_width_type w,
      input logic            down,
      input logic            up,
      input servo_width_type low,
      input servo_width_type high,
      input servo_width_type step
   );
      servo_width_type r;
      r = w;
      if (down && (w >= low)) begin
         r = w - step;
      end else if (up && (w <= high)) begin
         r = w + step;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mds_if.sv @@
// Valid/ready channel interfaces for the stick request and the drive response.
`default_nettype none

interface mds_req_if #(
   parameter int STICK_WIDTH = mds_pkg::STICK_WIDTH_DEF
);
   logic                                  valid;
   logic                                  ready;
   logic signed [STICK_WIDTH-1:0]         stick_forward;
   logic signed [STICK_WIDTH-1:0]         stick_sideways;
   logic signed [STICK_WIDTH-1:0]         stick_turn;
   logic [mds_pkg::BUTTON_WIDTH-1:0]      button_bits;
   logic [mds_pkg::SWITCH_WIDTH-1:0]      switch_bits;

   modport source (
      output valid, stick_forward, stick_sideways, stick_turn, button_bits, switch_bits,
      input  ready
   );
   modport sink (
      input  valid, stick_forward, stick_sideways, stick_turn, button_bits, switch_bits,
      output ready
   );
endinterface

interface mds_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mds_pkg::PWM_WIDTH-1:0]      motor1_fwd;
   logic [mds_pkg::PWM_WIDTH-1:0]      motor1_rev;
   logic [mds_pkg::PWM_WIDTH-1:0]      motor2_fwd;
   logic [mds_pkg::PWM_WIDTH-1:0]      motor2_rev;
   logic [mds_pkg::PWM_WIDTH-1:0]      motor3_fwd;
   logic [mds_pkg::PWM_WIDTH-1:0]      motor3_rev;
   logic [mds_pkg::PWM_WIDTH-1:0]      motor4_fwd;
   logic [mds_pkg::PWM_WIDTH-1:0]      motor4_rev;
   logic [mds_pkg::SERVO_WIDTH-1:0]    servo1_pulse;
   logic [mds_pkg::SERVO_WIDTH-1:0]    servo2_pulse;
   logic [mds_pkg::SERVO_WIDTH-1:0]    servo3_pulse;
   logic [mds_pkg::SERVO_WIDTH-1:0]    servo4_pulse;

   modport source (
      output valid, motor1_fwd, motor1_rev, motor2_fwd, motor2_rev,
             motor3_fwd, motor3_rev, motor4_fwd, motor4_rev,
             servo1_pulse, servo2_pulse, servo3_pulse, servo4_pulse,
      input  ready
   );
   modport sink (
      input  valid, motor1_fwd, motor1_rev, motor2_fwd, motor2_rev,
             motor3_fwd, motor3_rev, motor4_fwd, motor4_rev,
             servo1_pulse, servo2_pulse, servo3_pulse, servo4_pulse,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/mecanum_drive_and_servo_stepper.sv @@
// Mecanum wheel mixer with four stepping servo pulse registers.
//
// req_chan carries one control tick (three signed sticks, button and switch
// bits); rsp_chan returns one transaction per tick with eight PWM compare
// values (forward/reverse per wheel, one of each pair is zero) and the four
// servo pulse widths after this tick's step.
// Pipeline: an accepted request is held in the input register, then goes
// through the mixer and servo update into the response register, from
// which it is offered on rsp_chan.
// Throughput: one tick per cycle while rsp_chan.ready stays high. The only
// loop is the servo width update, a single add/compare per servo.
// Stall: the response register holds while rsp_chan.ready is low; one more
// tick is held in the input register, after which req_chan.ready drops.
// Reset: both pipeline stages empty, gains back to 10 (slow) and 50 (fast),
// servo widths to 1000, 1500, 1800 and 2500.
// csr: index 0 writes the slow gain, index 1 the fast gain; others ignored.
// Gains are sampled as a tick passes the mixer, so write them while idle.
`default_nettype none

module mecanum_drive_and_servo_stepper #(
   parameter int STICK_WIDTH = mds_pkg::STICK_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mds_req_if.sink                             req_chan,
   mds_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [mds_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [mds_pkg::GAIN_WIDTH-1:0]      csr_wdata
);
   import mds_pkg::*;

   logic [GAIN_WIDTH-1:0]           gain_slow_ff, gain_slow_in;
   logic [GAIN_WIDTH-1:0]           gain_fast_ff, gain_fast_in;

   logic                            s1_valid_ff, s1_valid_in;
   logic signed [STICK_WIDTH-1:0]   s1_fwd_ff;
   logic signed [STICK_WIDTH-1:0]   s1_side_ff;
   logic signed [STICK_WIDTH-1:0]   s1_turn_ff;
   logic [BUTTON_WIDTH-1:0]         s1_btn_ff;
   logic [SWITCH_WIDTH-1:0]         s1_sw_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [NUM_WHEELS-1:0][PWM_WIDTH-1:0] rsp_fwd_ff;
   logic [NUM_WHEELS-1:0][PWM_WIDTH-1:0] rsp_rev_ff;
   servo_width_type                 rsp_servo_ff [NUM_SERVOS];

   servo_width_type                 servo_width_ff [NUM_SERVOS];
   servo_width_type                 servo_width_in [NUM_SERVOS];
   logic [NUM_SERVOS-1:0]           down_req;
   logic [NUM_SERVOS-1:0]           up_req;

   logic                            advance;
   logic                            req_take;
   logic [GAIN_WIDTH-1:0]           gain_sel;
   logic [NUM_WHEELS-1:0][PWM_WIDTH-1:0] mix_fwd;
   logic [NUM_WHEELS-1:0][PWM_WIDTH-1:0] mix_rev;

   // handshake: stage 1 moves forward whenever the response slot is free
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in   = advance ? s1_valid_ff : rsp_valid_ff;

   // csr decode
   always_comb begin
      gain_slow_in = gain_slow_ff;
      gain_fast_in = gain_fast_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN_SLOW: gain_slow_in = csr_wdata;
            CSR_GAIN_FAST: gain_fast_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign gain_sel = s1_sw_ff[SW_GAIN_SEL] ? gain_fast_ff : gain_slow_ff;

   mds_mixer #(
      .STICK_WIDTH (STICK_WIDTH)
   ) u_mixer (
      .stick_forward  (s1_fwd_ff),
      .stick_sideways (s1_side_ff),
      .stick_turn     (s1_turn_ff),
      .gain           (gain_sel),
      .fwd            (mix_fwd),
      .rev            (mix_rev)
   );

   // servo 4 rises whenever its switch is off
   assign down_req = {s1_sw_ff[2], s1_sw_ff[0], s1_btn_ff[2], s1_btn_ff[0]};
   assign up_req   = {!s1_sw_ff[2], s1_sw_ff[1], s1_btn_ff[3], s1_btn_ff[1]};

   always_comb begin
      for (int k = 0; k < NUM_SERVOS; k++) begin
         servo_width_in[k] = servo_step(servo_width_ff[k], down_req[k], up_req[k],
                                        SERVO_LOW[k], SERVO_HIGH[k], SERVO_STEP[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_slow_ff <= GAIN_SLOW_RESET;
         gain_fast_ff <= GAIN_FAST_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_SERVOS; k++) begin
            servo_width_ff[k] <= SERVO_RESET[k];
         end
      end else begin
         gain_slow_ff <= gain_slow_in;
         gain_fast_ff <= gain_fast_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && s1_valid_ff) begin
            for (int k = 0; k < NUM_SERVOS; k++) begin
               servo_width_ff[k] <= servo_width_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_fwd_ff  <= req_chan.stick_forward;
         s1_side_ff <= req_chan.stick_sideways;
         s1_turn_ff <= req_chan.stick_turn;
         s1_btn_ff  <= req_chan.button_bits;
         s1_sw_ff   <= req_chan.switch_bits;
      end
      if (advance && s1_valid_ff) begin
         rsp_fwd_ff <= mix_fwd;
         rsp_rev_ff <= mix_rev;
         for (int k = 0; k < NUM_SERVOS; k++) begin
            rsp_servo_ff[k] <= servo_width_in[k];
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.motor1_fwd   = rsp_fwd_ff[0];
   assign rsp_chan.motor1_rev   = rsp_rev_ff[0];
   assign rsp_chan.motor2_fwd   = rsp_fwd_ff[1];
   assign rsp_chan.motor2_rev   = rsp_rev_ff[1];
   assign rsp_chan.motor3_fwd   = rsp_fwd_ff[2];
   assign rsp_chan.motor3_rev   = rsp_rev_ff[2];
   assign rsp_chan.motor4_fwd   = rsp_fwd_ff[3];
   assign rsp_chan.motor4_rev   = rsp_rev_ff[3];
   assign rsp_chan.servo1_pulse = rsp_servo_ff[0];
   assign rsp_chan.servo2_pulse = rsp_servo_ff[1];
   assign rsp_chan.servo3_pulse = rsp_servo_ff[2];
   assign rsp_chan.servo4_pulse = rsp_servo_ff[3];

`ifndef SYNTH
   // a tick stuck behind a stalled response stays in stage 1
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("stage 1 transaction dropped during stall");

   // servo state only moves when a tick leaves stage 1
   a_servo_frozen: assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_valid_ff) |=> (servo_width_ff[0] == $past(servo_width_ff[0]) &&
                                     servo_width_ff[1] == $past(servo_width_ff[1]) &&
                                     servo_width_ff[2] == $past(servo_width_ff[2]) &&
                                     servo_width_ff[3] == $past(servo_width_ff[3])))
      else $error("servo width changed without a transaction");

   // widths stay between 400 and 2600
   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      servo_width_ff[0] >= 12'd400 && servo_width_ff[0] <= 12'd2600 &&
      servo_width_ff[1] >= 12'd400 && servo_width_ff[1] <= 12'd2600 &&
      servo_width_ff[2] >= 12'd400 && servo_width_ff[2] <= 12'd2600 &&
      servo_width_ff[3] >= 12'd400 && servo_width_ff[3] <= 12'd2600)
      else $error("servo width out of range");

   // response pulses of servos 1 and 4 match the servo state they came from
   a_rsp_servo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_servo_ff[0] == servo_width_ff[0] &&
                        rsp_servo_ff[3] == servo_width_ff[3]))
      else $error("response servo pulse out of step with state");

   // forward and reverse of a wheel are never both driven
   a_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_fwd_ff[0] == '0 || rsp_rev_ff[0] == '0) &&
                        (rsp_fwd_ff[1] == '0 || rsp_rev_ff[1] == '0) &&
                        (rsp_fwd_ff[2] == '0 || rsp_rev_ff[2] == '0) &&
                        (rsp_fwd_ff[3] == '0 || rsp_rev_ff[3] == '0)))
      else $error("both directions driven on one wheel");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/mds_mixer.sv @@
// Mecanum mixing of three sticks into four wheel speeds, gain and fwd/rev split.
`default_nettype none

module mds_mixer #(
   parameter int STICK_WIDTH = mds_pkg::STICK_WIDTH_DEF
) (
   input  logic signed [STICK_WIDTH-1:0]                            stick_forward,
   input  logic signed [STICK_WIDTH-1:0]                            stick_sideways,
   input  logic signed [STICK_WIDTH-1:0]                            stick_turn,
   input  logic [mds_pkg::GAIN_WIDTH-1:0]                           gain,
   output logic [mds_pkg::NUM_WHEELS-1:0][mds_pkg::PWM_WIDTH-1:0]   fwd,
   output logic [mds_pkg::NUM_WHEELS-1:0][mds_pkg::PWM_WIDTH-1:0]   rev
);
   import mds_pkg::*;

   localparam int SumWidth  = STICK_WIDTH + 2;
   localparam int MagWidth  = STICK_WIDTH + 1;
   localparam int ProdWidth = MagWidth + GAIN_WIDTH;

   logic signed [SumWidth-1:0]  f_ext;
   logic signed [SumWidth-1:0]  s_ext;
   logic signed [SumWidth-1:0]  t_ext;
   logic signed [SumWidth-1:0]  speed [NUM_WHEELS];
   logic signed [SumWidth-1:0]  neg   [NUM_WHEELS];
   logic                        pos   [NUM_WHEELS];
   logic [MagWidth-1:0]         mag   [NUM_WHEELS];
   logic [ProdWidth-1:0]        prod  [NUM_WHEELS];
   logic [PWM_WIDTH-1:0]        sat   [NUM_WHEELS];

   assign f_ext = SumWidth'(stick_forward);
   assign s_ext = SumWidth'(stick_sideways);
   assign t_ext = SumWidth'(stick_turn);

   assign speed[0] =  f_ext + s_ext + t_ext;
   assign speed[1] =  f_ext - s_ext + t_ext;
   assign speed[2] = -f_ext + s_ext + t_ext;
   assign speed[3] = -f_ext - s_ext + t_ext;

   always_comb begin
      for (int k = 0; k < NUM_WHEELS; k++) begin
         pos[k]  = !speed[k][SumWidth-1] && (speed[k] != '0);
         neg[k]  = -speed[k];
         // |speed| <= 3 * 2^(STICK_WIDTH-1), fits in MagWidth bits
         mag[k]  = pos[k] ? speed[k][MagWidth-1:0] : neg[k][MagWidth-1:0];
         prod[k] = ProdWidth'(mag[k]) * ProdWidth'(gain);
         sat[k]  = (prod[k] > ProdWidth'(PWM_MAX)) ? PWM_MAX : prod[k][PWM_WIDTH-1:0];
         fwd[k]  = pos[k] ? sat[k] : '0;
         rev[k]  = pos[k] ? '0 : sat[k];
      end
   end

endmodule

`default_nettype wire

@@ bench/mds_checker.sv @@
// Response checker for the mecanum drive block: predicts every tick and compares the response.
`timescale 1ns / 1ps

module mds_checker (
   input  logic                                clock,
   input  logic                                reset,
   mds_req_if                                  req_mon,
   mds_rsp_if                                  rsp_mon,
   input  logic                                csr_wr_en,
   input  logic [mds_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [mds_pkg::GAIN_WIDTH-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  checked_count
);
   import mds_pkg::*;

   // pwm[2*wheel] is the forward compare, pwm[2*wheel+1] the reverse one
   typedef struct packed {
      logic [2*NUM_WHEELS-1:0][PWM_WIDTH-1:0]  pwm;
      logic [NUM_SERVOS-1:0][SERVO_WIDTH-1:0]  pulse;
   } drive_frame_type;

   logic [GAIN_WIDTH-1:0] gain_slow;
   logic [GAIN_WIDTH-1:0] gain_fast;
   servo_width_type       servo_width [NUM_SERVOS];
   drive_frame_type       expected_drive_q [$];

   function automatic logic [PWM_WIDTH-1:0] scaled_compare(input int mag, input int gain);
      int p;
      p = mag * gain;
      if (p > int'(PWM_MAX)) begin
         p = int'(PWM_MAX);
      end
      return p[PWM_WIDTH-1:0];
   endfunction

   // limit is checked ahead of the step, so one overshoot past it is legal
   function automatic servo_width_type stepped_width(input int idx, input servo_width_type w,
                                                     input logic lower, input logic raise);
      if (lower && (w >= SERVO_LOW[idx])) begin
         return w - SERVO_STEP[idx];
      end
      if (raise && (w <= SERVO_HIGH[idx])) begin
         return w + SERVO_STEP[idx];
      end
      return w;
   endfunction

   function automatic drive_frame_type mix_and_step(
      input logic signed [STICK_WIDTH_DEF-1:0] fwd,
      input logic signed [STICK_WIDTH_DEF-1:0] side,
      input logic signed [STICK_WIDTH_DEF-1:0] turn,
      input logic [BUTTON_WIDTH-1:0]           btn,
      input logic [SWITCH_WIDTH-1:0]           sw
   );
      drive_frame_type frame;
      int           f, s, t, gain, k;
      int           speed [NUM_WHEELS];
      logic         lower [NUM_SERVOS];
      logic         raise [NUM_SERVOS];
      f = int'(fwd);
      s = int'(side);
      t = int'(turn);
      gain = sw[SW_GAIN_SEL] ? int'(gain_fast) : int'(gain_slow);
      speed[0] = f + s + t;
      speed[1] = f - s + t;
      speed[2] = -f + s + t;
      speed[3] = -f - s + t;
      for (k = 0; k < NUM_WHEELS; k++) begin
         if (speed[k] > 0) begin
            frame.pwm[2*k]   = scaled_compare(speed[k], gain);
            frame.pwm[2*k+1] = '0;
         end else begin
            frame.pwm[2*k]   = '0;
            frame.pwm[2*k+1] = scaled_compare(-speed[k], gain);
         end
      end
      lower[0] = btn[0];  raise[0] = btn[1];
      lower[1] = btn[2];  raise[1] = btn[3];
      lower[2] = sw[0];   raise[2] = sw[1];
      lower[3] = sw[2];   raise[3] = !sw[2];
      for (k = 0; k < NUM_SERVOS; k++) begin
         frame.pulse[k] = stepped_width(k, servo_width[k], lower[k], raise[k]);
      end
      return frame;
   endfunction

   task automatic note_mismatch(input string field, input int want, input int got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: mismatch on %s in transaction %0d: expected %0d, got %0d",
                  $time, field, checked_count, want, got);
      end
   endtask

   always @(posedge clock) begin
      drive_frame_type want;
      drive_frame_type got;
      int           k;
      if (reset) begin
         gain_slow = GAIN_SLOW_RESET;
         gain_fast = GAIN_FAST_RESET;
         servo_width = SERVO_RESET;
         expected_drive_q.delete();
         fail_count = 0;
         checked_count = 0;
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_GAIN_SLOW) begin
               gain_slow = csr_wdata;
            end else if (csr_index == CSR_GAIN_FAST) begin
               gain_fast = csr_wdata;
            end
         end
         // responses first: one accepted at this edge never belongs to a tick taken now
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.pwm[0]   = rsp_mon.motor1_fwd;
            got.pwm[1]   = rsp_mon.motor1_rev;
            got.pwm[2]   = rsp_mon.motor2_fwd;
            got.pwm[3]   = rsp_mon.motor2_rev;
            got.pwm[4]   = rsp_mon.motor3_fwd;
            got.pwm[5]   = rsp_mon.motor3_rev;
            got.pwm[6]   = rsp_mon.motor4_fwd;
            got.pwm[7]   = rsp_mon.motor4_rev;
            got.pulse[0] = rsp_mon.servo1_pulse;
            got.pulse[1] = rsp_mon.servo2_pulse;
            got.pulse[2] = rsp_mon.servo3_pulse;
            got.pulse[3] = rsp_mon.servo4_pulse;
            if (expected_drive_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: response transaction with no tick outstanding", $time);
               end
            end else begin
               want = expected_drive_q.pop_front();
               for (k = 0; k < 2*NUM_WHEELS; k++) begin
                  if (got.pwm[k] !== want.pwm[k]) begin
                     note_mismatch($sformatf("motor%0d_%s", k/2 + 1, (k % 2) ? "rev" : "fwd"),
                                   int'(want.pwm[k]), int'(got.pwm[k]));
                  end
               end
               for (k = 0; k < NUM_SERVOS; k++) begin
                  if (got.pulse[k] !== want.pulse[k]) begin
                     note_mismatch($sformatf("servo%0d_pulse", k + 1),
                                   int'(want.pulse[k]), int'(got.pulse[k]));
                  end
               end
               checked_count++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want = mix_and_step(req_mon.stick_forward, req_mon.stick_sideways,
                                req_mon.stick_turn, req_mon.button_bits, req_mon.switch_bits);
            for (k = 0; k < NUM_SERVOS; k++) begin
               servo_width[k] = want.pulse[k];
            end
            expected_drive_q.push_back(want);
         end
         pending <= expected_drive_q.size();
      end
   end

endmodule

@@ bench/tb.sv @@
// Top of the mecanum drive testbench: clock, reset, stimulus, gain programming and verdict.
`timescale 1ns / 1ps

module tb;
   import mds_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_B = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [GAIN_WIDTH-1:0]     csr_wdata;
   int                        fail_count;
   int                        pending;
   int                        checked_count;
   int                        req_idle_pct = 8;
   int                        rsp_idle_pct = 67;
   int                        ticks_sent = 0;
   int                        gain_settings = 1;

   mds_req_if req_chan ();
   mds_rsp_if rsp_chan ();

   mecanum_drive_and_servo_stepper dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mds_checker drive_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("mecanum_drive_and_servo_stepper test failed");
      $finish;
   end

   // response side back-pressure
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_tick(input logic [7:0] fwd, input logic [7:0] side,
                            input logic [7:0] turn, input logic [3:0] btn,
                            input logic [3:0] sw);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.stick_forward  <= fwd;
      req_chan.stick_sideways <= side;
      req_chan.stick_turn     <= turn;
      req_chan.button_bits    <= btn;
      req_chan.switch_bits    <= sw;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      ticks_sent++;
   endtask

   // returns once every outstanding response has been checked and the pipe is empty
   task automatic drain_to_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // spare indexes go last so an aliased decode would clobber a gain and show up
   task automatic program_gains(input logic [7:0] slow, input logic [7:0] fast);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GAIN_SLOW;
      csr_wdata <= slow;
      @(posedge clock);
      csr_index <= CSR_GAIN_FAST;
      csr_wdata <= fast;
      @(posedge clock);
      csr_index <= CSR_SPARE_A;
      csr_wdata <= 8'($urandom);
      @(posedge clock);
      csr_index <= CSR_SPARE_B;
      csr_wdata <= 8'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      gain_settings++;
   endtask

   function automatic logic [7:0] pick_stick();
      case ($urandom_range(9))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   // runs of ticks that push the servos down or up, mixed with fully random ones
   task automatic run_random(input int count);
      int         i;
      int         mode;
      logic [3:0] btn;
      logic [3:0] sw;
      mode = 0;
      for (i = 0; i < count; i++) begin
         if (i % 32 == 0) begin
            mode = $urandom_range(2);
         end
         case (mode)
            1: begin
               btn = 4'b1010;
               sw  = {1'($urandom), 3'b010};
            end
            2: begin
               btn = 4'b0101;
               sw  = {1'($urandom), 3'b101};
            end
            default: begin
               btn = 4'($urandom);
               sw  = 4'($urandom);
            end
         endcase
         if ($urandom_range(7) == 0) begin
            btn = btn ^ 4'($urandom);
            sw  = sw ^ 4'($urandom);
         end
         send_tick(pick_stick(), pick_stick(), pick_stick(), btn, sw);
      end
   endtask

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.stick_forward  <= '0;
      req_chan.stick_sideways <= '0;
      req_chan.stick_turn     <= '0;
      req_chan.button_bits    <= '0;
      req_chan.switch_bits    <= '0;
      csr_wr_en               <= 1'b0;
      csr_index               <= CSR_GAIN_SLOW;
      csr_wdata               <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed ticks at reset gains
      send_tick(8'h00, 8'h00, 8'h00, 4'b0000, 4'b0000);
      send_tick(8'h7F, 8'h7F, 8'h7F, 4'b0000, 4'b1000);
      send_tick(8'h80, 8'h80, 8'h80, 4'b0000, 4'b1000);
      send_tick(8'h7F, 8'h80, 8'h7F, 4'b0000, 4'b0000);
      send_tick(8'h80, 8'h7F, 8'h80, 4'b0000, 4'b1000);
      send_tick(8'h80, 8'h7F, 8'h7F, 4'b0000, 4'b0000);
      send_tick(8'h05, 8'hFB, 8'h00, 4'b0011, 4'b0000);
      send_tick(8'h00, 8'h00, 8'h80, 4'b1100, 4'b0011);
      send_tick(8'h00, 8'h00, 8'h7F, 4'b1111, 4'b1111);
      send_tick(8'hFF, 8'hFF, 8'hFF, 4'b1010, 4'b0010);
      send_tick(8'h01, 8'h00, 8'h00, 4'b0101, 4'b0101);
      send_tick(8'h00, 8'h01, 8'h00, 4'b0001, 4'b0100);
      send_tick(8'h00, 8'h00, 8'h01, 4'b0010, 4'b1001);
      send_tick(8'h7F, 8'h7F, 8'h80, 4'b0100, 4'b1010);
      send_tick(8'h80, 8'h80, 8'h7F, 4'b1000, 4'b1100);
      send_tick(8'h40, 8'hC0, 8'h00, 4'b0000, 4'b0110);

      drain_to_idle();
      program_gains(8'hFF, 8'h00);
      run_random(370);

      drain_to_idle();
      req_idle_pct <= 67;
      rsp_idle_pct <= 8;
      program_gains(8'($urandom), 8'($urandom));
      run_random(370);

      drain_to_idle();
      req_idle_pct <= 0;
      rsp_idle_pct <= 0;
      program_gains(8'h00, 8'hFF);
      run_random(370);

      drain_to_idle();
      $display("Ran %0d control ticks across %0d gain settings with random stalls on both sides.",
               ticks_sent, gain_settings);
      $display("Checked %0d response transactions field by field.", checked_count);
      if (fail_count == 0 && pending == 0) begin
         $display("mecanum_drive_and_servo_stepper test passed");
      end else begin
         $display("mecanum_drive_and_servo_stepper test failed");
      end
      $finish;
   end

endmodule
